[hdl/pbfs_pkg.sv]
`default_nettype none
package pbfs_pkg;

	localparam int OP_W   = 2;
	localparam int BANK_W = 3;
	localparam int TAG_W  = 16;
	localparam int OCC_W  = 8;
	localparam int ERR_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_PUT        = 2'd0,
		OP_NEXT       = 2'd1,
		OP_COMPLETE   = 2'd2,
		OP_RESCHEDULE = 2'd3
	} op_t;

	localparam logic [ERR_W-1:0] ERR_OK          = 3'd0;
	localparam logic [ERR_W-1:0] ERR_BANK_FULL   = 3'd1;
	localparam logic [ERR_W-1:0] ERR_BANK_EMPTY  = 3'd2;
	localparam logic [ERR_W-1:0] ERR_SCHED_EMPTY = 3'd3;
	localparam logic [ERR_W-1:0] ERR_SCHED_FULL  = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic pop;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_next;
		logic sched_empty;
		logic bank_empty;
	} sts_t;

endpackage
`default_nettype wire

[hdl/per_bank_fifo_request_scheduler_unit.sv]
// Channel  | Handshake          | Fields
// ---------+--------------------+------------------------------------------------------
// command  | start, busy        | op, bank, request_tag, bank_pending
// result   | done (one cycle)   | issued_valid, issued_bank, issued_tag, banks_waiting,
//          |                    | occupancy, error_code
//
// An item is taken when start is high and busy is low. done is registered after the exec state for
// put, complete, reschedule and a next on an empty schedule, after the pop state for a next
// whose bank is empty, and after the tag state for a next that issues a tag. The registered
// reads of the schedule memory and the tag memory add the pop and tag states.
// busy is already low while done is high, so a new item can be taken in that cycle.
// Reset clears all queue pointers and counts at once; the receiver cannot stall.
`default_nettype none
module per_bank_fifo_request_scheduler_unit #(
	parameter int BANK_COUNT  = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int SCHED_DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [pbfs_pkg::OP_W-1:0]     op,
	input  wire logic [pbfs_pkg::BANK_W-1:0]   bank,
	input  wire logic [pbfs_pkg::TAG_W-1:0]    request_tag,
	input  wire logic                          bank_pending,
	output logic                               done,
	output logic                               issued_valid,
	output logic [pbfs_pkg::BANK_W-1:0]        issued_bank,
	output logic [pbfs_pkg::TAG_W-1:0]         issued_tag,
	output logic                               banks_waiting,
	output logic [pbfs_pkg::OCC_W-1:0]         occupancy,
	output logic [pbfs_pkg::ERR_W-1:0]         error_code
);

	pbfs_pkg::cmd_t cmd;
	pbfs_pkg::sts_t sts;

	pbfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	pbfs_datapath #(
		.BANK_COUNT  (BANK_COUNT),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.SCHED_DEPTH (SCHED_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.bank          (bank),
		.request_tag   (request_tag),
		.bank_pending  (bank_pending),
		.done          (done),
		.issued_valid  (issued_valid),
		.issued_bank   (issued_bank),
		.issued_tag    (issued_tag),
		.banks_waiting (banks_waiting),
		.occupancy     (occupancy),
		.error_code    (error_code)
	);

endmodule
`default_nettype wire

[hdl/pbfs_ctrl.sv]
`default_nettype none
module pbfs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire pbfs_pkg::sts_t sts,
	output logic               busy,
	output pbfs_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_TAG
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
						busy_q  <= 1'b1;
					end
				end
				ST_EXEC: begin
					if (sts.op_next && !sts.sched_empty) begin
						state_q <= ST_POP;
					end else begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_POP: begin
					if (sts.bank_empty) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= ST_TAG;
					end
				end
				ST_TAG: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy        = busy_q;
	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.pop     = (state_q == ST_POP);
	assign cmd.finish  = (state_q == ST_TAG);

endmodule
`default_nettype wire

[hdl/pbfs_datapath.sv]
`default_nettype none
module pbfs_datapath #(
	parameter int BANK_COUNT  = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int SCHED_DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pbfs_pkg::cmd_t                cmd,
	output pbfs_pkg::sts_t                     sts,
	input  wire logic [pbfs_pkg::OP_W-1:0]     op,
	input  wire logic [pbfs_pkg::BANK_W-1:0]   bank,
	input  wire logic [pbfs_pkg::TAG_W-1:0]    request_tag,
	input  wire logic                          bank_pending,
	output logic                               done,
	output logic                               issued_valid,
	output logic [pbfs_pkg::BANK_W-1:0]        issued_bank,
	output logic [pbfs_pkg::TAG_W-1:0]         issued_tag,
	output logic                               banks_waiting,
	output logic [pbfs_pkg::OCC_W-1:0]         occupancy,
	output logic [pbfs_pkg::ERR_W-1:0]         error_code
);

	localparam int BW  = $clog2(BANK_COUNT);
	localparam int QW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int SW  = $clog2(SCHED_DEPTH);
	localparam int SCW = $clog2(SCHED_DEPTH + 1);
	localparam int AW  = BW + QW;

	// Captured item.
	logic [pbfs_pkg::OP_W-1:0]   op_q;
	logic [pbfs_pkg::BANK_W-1:0] bank_q;
	logic [pbfs_pkg::TAG_W-1:0]  tag_q;
	logic                        pend_q;

	// Per-bank queue state.
	logic [QW-1:0] head_q [BANK_COUNT];
	logic [QW-1:0] tail_q [BANK_COUNT];
	logic [CW-1:0] cnt_q  [BANK_COUNT];

	// Schedule queue state.
	logic [SW-1:0]  sched_head_q;
	logic [SW-1:0]  sched_tail_q;
	logic [SCW-1:0] sched_cnt_q;
	logic [pbfs_pkg::OCC_W-1:0] total_q;

	// Memories and their read registers.
	logic [pbfs_pkg::TAG_W-1:0] bmem [2**AW];
	logic [BW-1:0]              smem [SCHED_DEPTH];
	logic [pbfs_pkg::TAG_W-1:0] brd_q;
	logic [BW-1:0]              sched_rd_q;

	// Result registers.
	logic                        done_q;
	logic                        iv_q;
	logic [pbfs_pkg::BANK_W-1:0] ib_q;
	logic [pbfs_pkg::TAG_W-1:0]  it_q;
	logic [pbfs_pkg::ERR_W-1:0]  err_q;

	logic          bank_ok;
	logic [BW-1:0] bank_idx;
	logic [BW-1:0] sel_idx;
	logic [QW-1:0] sel_head;
	logic [QW-1:0] sel_tail;
	logic [CW-1:0] sel_cnt;
	logic [QW-1:0] head_nxt;
	logic [QW-1:0] tail_nxt;
	logic          sched_full;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	logic                        bwr, push, sched_rd_en, pop_en, bank_rd_en;
	logic                        hd_inc, tl_inc, cnt_inc, cnt_dec, res_load;
	logic                        iv;
	logic [pbfs_pkg::BANK_W-1:0] ib;
	logic [pbfs_pkg::TAG_W-1:0]  it;
	logic [pbfs_pkg::ERR_W-1:0]  err;

	assign bank_ok    = 32'(bank_q) < 32'(BANK_COUNT);
	assign bank_idx   = BW'(bank_q);
	// During the pop step the bank comes from the schedule queue, else from the item.
	assign sel_idx    = cmd.pop ? sched_rd_q : bank_idx;
	assign sel_head   = head_q[sel_idx];
	assign sel_tail   = tail_q[sel_idx];
	assign sel_cnt    = cnt_q[sel_idx];
	assign head_nxt   = (sel_head == QW'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;
	assign tail_nxt   = (sel_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : sel_tail + 1'b1;
	assign sched_full = (sched_cnt_q == SCW'(SCHED_DEPTH));
	assign wr_addr    = {bank_idx, sel_tail};
	assign rd_addr    = {sched_rd_q, sel_head};

	assign sts.op_next     = (op_q == pbfs_pkg::OP_NEXT);
	assign sts.sched_empty = (sched_cnt_q == '0);
	assign sts.bank_empty  = (sel_cnt == '0);

	always_comb begin
		bwr         = 1'b0;
		push        = 1'b0;
		sched_rd_en = 1'b0;
		pop_en      = 1'b0;
		bank_rd_en  = 1'b0;
		hd_inc      = 1'b0;
		tl_inc      = 1'b0;
		cnt_inc     = 1'b0;
		cnt_dec     = 1'b0;
		res_load    = 1'b0;
		iv          = 1'b0;
		ib          = '0;
		it          = '0;
		err         = pbfs_pkg::ERR_OK;
		if (cmd.exec) begin
			case (op_q)
				pbfs_pkg::OP_NEXT: begin
					if (sched_cnt_q == '0) begin
						err      = pbfs_pkg::ERR_SCHED_EMPTY;
						res_load = 1'b1;
					end else begin
						sched_rd_en = 1'b1;
					end
				end
				pbfs_pkg::OP_PUT: begin
					res_load = 1'b1;
					if (bank_ok) begin
						if (sel_cnt == CW'(QUEUE_DEPTH)) begin
							err = pbfs_pkg::ERR_BANK_FULL;
						end else begin
							bwr     = 1'b1;
							tl_inc  = 1'b1;
							cnt_inc = 1'b1;
							// A bank that just got its first item joins the schedule unless bank_pending was set or the schedule is full.
							if (sel_cnt == '0 && !pend_q) begin
								if (sched_full) begin
									err = pbfs_pkg::ERR_SCHED_FULL;
								end else begin
									push = 1'b1;
								end
							end
						end
					end
				end
				pbfs_pkg::OP_COMPLETE: begin
					res_load = 1'b1;
					if (bank_ok) begin
						if (sel_cnt == '0) begin
							err = pbfs_pkg::ERR_BANK_EMPTY;
						end else begin
							hd_inc  = 1'b1;
							cnt_dec = 1'b1;
						end
					end
				end
				pbfs_pkg::OP_RESCHEDULE: begin
					res_load = 1'b1;
					if (bank_ok && sel_cnt != '0) begin
						if (sched_full) begin
							err = pbfs_pkg::ERR_SCHED_FULL;
						end else begin
							push = 1'b1;
						end
					end
				end
				default: begin
					res_load = 1'b1;
				end
			endcase
		end else if (cmd.pop) begin
			pop_en = 1'b1;
			ib     = pbfs_pkg::BANK_W'(sched_rd_q);
			if (sel_cnt == '0) begin
				err      = pbfs_pkg::ERR_BANK_EMPTY;
				res_load = 1'b1;
			end else begin
				bank_rd_en = 1'b1;
			end
		end else if (cmd.finish) begin
			iv       = 1'b1;
			ib       = pbfs_pkg::BANK_W'(sched_rd_q);
			it       = brd_q;
			res_load = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			bank_q <= bank;
			tag_q  <= request_tag;
			pend_q <= bank_pending;
		end
	end

	always_ff @(posedge clk) begin
		if (bwr) begin
			bmem[wr_addr] <= tag_q;
		end
		if (bank_rd_en) begin
			brd_q <= bmem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			smem[sched_tail_q] <= bank_idx;
		end
		if (sched_rd_en) begin
			sched_rd_q <= smem[sched_head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANK_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			sched_head_q <= '0;
			sched_tail_q <= '0;
			sched_cnt_q  <= '0;
			total_q      <= '0;
		end else begin
			if (hd_inc) begin
				head_q[sel_idx] <= head_nxt;
			end
			if (tl_inc) begin
				tail_q[sel_idx] <= tail_nxt;
			end
			if (cnt_inc) begin
				cnt_q[sel_idx] <= sel_cnt + 1'b1;
				total_q        <= total_q + 1'b1;
			end else if (cnt_dec) begin
				cnt_q[sel_idx] <= sel_cnt - 1'b1;
				total_q        <= total_q - 1'b1;
			end
			if (push) begin
				sched_tail_q <= (sched_tail_q == SW'(SCHED_DEPTH - 1)) ? '0
					: sched_tail_q + 1'b1;
				sched_cnt_q  <= sched_cnt_q + 1'b1;
			end else if (pop_en) begin
				sched_head_q <= (sched_head_q == SW'(SCHED_DEPTH - 1)) ? '0
					: sched_head_q + 1'b1;
				sched_cnt_q  <= sched_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			iv_q  <= iv;
			ib_q  <= ib;
			it_q  <= it;
			err_q <= err;
		end
	end

	// Queue state does not change while a result is shown, so these track it directly.
	assign done          = done_q;
	assign issued_valid  = iv_q;
	assign issued_bank   = ib_q;
	assign issued_tag    = it_q;
	assign error_code    = err_q;
	assign banks_waiting = (sched_cnt_q != '0);
	assign occupancy     = total_q;

	a_sched_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sched_cnt_q <= SCW'(SCHED_DEPTH))
		else $error("schedule count exceeds depth");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_issue_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && iv_q) |-> (err_q == pbfs_pkg::ERR_OK))
		else $error("issued item reported with an error");

	a_tag_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> $past(cmd.pop))
		else $error("tag step without a preceding pop");

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	localparam int BANK_COUNT  = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int SCHED_DEPTH = 16;
	localparam int EXP_DEPTH   = 16;

	typedef struct packed {
		logic                        iv;
		logic [pbfs_pkg::BANK_W-1:0] ib;
		logic [pbfs_pkg::TAG_W-1:0]  it;
		logic                        bw;
		logic [pbfs_pkg::OCC_W-1:0]  occ;
		logic [pbfs_pkg::ERR_W-1:0]  err;
	} sched_result_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [pbfs_pkg::OP_W-1:0]   op;
	logic [pbfs_pkg::BANK_W-1:0] bank;
	logic [pbfs_pkg::TAG_W-1:0]  request_tag;
	logic                        bank_pending;
	logic                        done;
	logic                        issued_valid;
	logic [pbfs_pkg::BANK_W-1:0] issued_bank;
	logic [pbfs_pkg::TAG_W-1:0]  issued_tag;
	logic                        banks_waiting;
	logic [pbfs_pkg::OCC_W-1:0]  occupancy;
	logic [pbfs_pkg::ERR_W-1:0]  error_code;

	// Scheduler state as the testbench expects it to be.
	// Pointers are four bits wide, so they wrap at the depth of 16 by themselves.
	logic [pbfs_pkg::TAG_W-1:0]  tag_store [BANK_COUNT][QUEUE_DEPTH];
	logic [3:0]                  bq_head [BANK_COUNT];
	logic [3:0]                  bq_tail [BANK_COUNT];
	logic [4:0]                  bq_cnt [BANK_COUNT];
	logic [pbfs_pkg::BANK_W-1:0] sched_store [SCHED_DEPTH];
	logic [3:0]                  sched_head;
	logic [3:0]                  sched_tail;
	logic [4:0]                  sched_cnt;
	logic [pbfs_pkg::OCC_W-1:0]  held_total;

	// Predictions waiting for their results, oldest at exp_rd.
	sched_result_t expected_ring [EXP_DEPTH];
	int            exp_wr;
	int            exp_rd;
	sched_result_t last_prediction;
	int            mismatch_count;
	bit            gaps_on;

	per_bank_fifo_request_scheduler_unit #(
		.BANK_COUNT(BANK_COUNT),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.SCHED_DEPTH(SCHED_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.bank(bank),
		.request_tag(request_tag),
		.bank_pending(bank_pending),
		.done(done),
		.issued_valid(issued_valid),
		.issued_bank(issued_bank),
		.issued_tag(issued_tag),
		.banks_waiting(banks_waiting),
		.occupancy(occupancy),
		.error_code(error_code)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic reset_model();
		for (int b = 0; b < BANK_COUNT; b++) begin
			bq_head[b] = '0;
			bq_tail[b] = '0;
			bq_cnt[b]  = '0;
			for (int i = 0; i < QUEUE_DEPTH; i++)
				tag_store[b][i] = '0;
		end
		for (int i = 0; i < SCHED_DEPTH; i++)
			sched_store[i] = '0;
		sched_head = '0;
		sched_tail = '0;
		sched_cnt  = '0;
		held_total = '0;
	endtask

	function automatic int outstanding();
		return exp_wr - exp_rd;
	endfunction

	function automatic logic [pbfs_pkg::TAG_W-1:0] rand_tag();
		return pbfs_pkg::TAG_W'($urandom);
	endfunction

	function automatic logic [pbfs_pkg::BANK_W-1:0] rand_bank();
		return pbfs_pkg::BANK_W'($urandom);
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic bit enqueue_bank(logic [pbfs_pkg::BANK_W-1:0] b);
		if (sched_cnt == SCHED_DEPTH)
			return 1'b0;
		sched_store[sched_tail] = b;
		sched_tail++;
		sched_cnt++;
		return 1'b1;
	endfunction

	function automatic sched_result_t predict_result(pbfs_pkg::op_t o,
			logic [pbfs_pkg::BANK_W-1:0] b, logic [pbfs_pkg::TAG_W-1:0] t, logic p);
		sched_result_t r;
		logic [pbfs_pkg::BANK_W-1:0] popped;
		r = '0;
		r.err = pbfs_pkg::ERR_OK;
		case (o)
			pbfs_pkg::OP_NEXT: begin
				if (sched_cnt == 0) begin
					r.err = pbfs_pkg::ERR_SCHED_EMPTY;
				end else begin
					popped = sched_store[sched_head];
					sched_head++;
					sched_cnt--;
					r.ib = popped;
					if (bq_cnt[popped] != 0) begin
						r.iv = 1'b1;
						r.it = tag_store[popped][bq_head[popped]];
					end else begin
						r.err = pbfs_pkg::ERR_BANK_EMPTY;
					end
				end
			end
			pbfs_pkg::OP_PUT: begin
				if (bq_cnt[b] == QUEUE_DEPTH) begin
					r.err = pbfs_pkg::ERR_BANK_FULL;
				end else begin
					tag_store[b][bq_tail[b]] = t;
					bq_tail[b]++;
					bq_cnt[b]++;
					held_total++;
					if (bq_cnt[b] == 1 && !p && !enqueue_bank(b))
						r.err = pbfs_pkg::ERR_SCHED_FULL;
				end
			end
			pbfs_pkg::OP_COMPLETE: begin
				if (bq_cnt[b] == 0) begin
					r.err = pbfs_pkg::ERR_BANK_EMPTY;
				end else begin
					bq_head[b]++;
					bq_cnt[b]--;
					held_total--;
				end
			end
			default: begin
				if (bq_cnt[b] != 0 && !enqueue_bank(b))
					r.err = pbfs_pkg::ERR_SCHED_FULL;
			end
		endcase
		r.bw  = (sched_cnt != 0);
		r.occ = held_total;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// Every result is checked against the oldest outstanding prediction.
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (outstanding() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				want = expected_ring[exp_rd % EXP_DEPTH];
				exp_rd++;
				check_field("issued_valid", 32'(issued_valid), 32'(want.iv));
				check_field("issued_bank", 32'(issued_bank), 32'(want.ib));
				check_field("issued_tag", 32'(issued_tag), 32'(want.it));
				check_field("banks_waiting", 32'(banks_waiting), 32'(want.bw));
				check_field("occupancy", 32'(occupancy), 32'(want.occ));
				check_field("error_code", 32'(error_code), 32'(want.err));
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Called at a falling edge; returns at a falling edge after the item is taken.
	task automatic send_cmd(pbfs_pkg::op_t o, logic [pbfs_pkg::BANK_W-1:0] b,
			logic [pbfs_pkg::TAG_W-1:0] t, logic p);
		int gap;
		start        <= 1'b1;
		op           <= o;
		bank         <= b;
		request_tag  <= t;
		bank_pending <= p;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		last_prediction = predict_result(o, b, t, p);
		expected_ring[exp_wr % EXP_DEPTH] = last_prediction;
		exp_wr++;
		@(negedge clk);
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		while (outstanding() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_directed();
		send_cmd(pbfs_pkg::OP_NEXT, 3'd0, 16'h0000, 1'b0);
		send_cmd(pbfs_pkg::OP_COMPLETE, 3'd0, 16'h0000, 1'b0);
		send_cmd(pbfs_pkg::OP_RESCHEDULE, 3'd7, 16'h0000, 1'b0);
		send_cmd(pbfs_pkg::OP_PUT, 3'd0, 16'h0000, 1'b0);
		send_cmd(pbfs_pkg::OP_PUT, 3'd7, 16'hFFFF, 1'b1);
		send_cmd(pbfs_pkg::OP_PUT, 3'd7, 16'h5555, 1'b0);
		send_cmd(pbfs_pkg::OP_RESCHEDULE, 3'd7, 16'h0000, 1'b0);
		send_cmd(pbfs_pkg::OP_NEXT, 3'd0, 16'h0000, 1'b0);
		send_cmd(pbfs_pkg::OP_COMPLETE, 3'd0, 16'h0000, 1'b0);
		send_cmd(pbfs_pkg::OP_RESCHEDULE, 3'd0, 16'h0000, 1'b0);
		send_cmd(pbfs_pkg::OP_PUT, 3'd0, 16'hAAAA, 1'b0);
		// Bank 0 is dropped empty while it still sits in the schedule.
		send_cmd(pbfs_pkg::OP_COMPLETE, 3'd0, 16'h0000, 1'b0);
		send_cmd(pbfs_pkg::OP_NEXT, 3'd0, 16'h0000, 1'b0);
		send_cmd(pbfs_pkg::OP_NEXT, 3'd0, 16'h0000, 1'b0);
		send_cmd(pbfs_pkg::OP_NEXT, 3'd0, 16'h0000, 1'b0);
		repeat (3) send_cmd(pbfs_pkg::OP_COMPLETE, 3'd7, 16'h0000, 1'b0);
	endtask

	// Starts with every queue empty.
	task automatic test_schedule_overflow();
		logic [pbfs_pkg::BANK_W-1:0] b;
		logic [pbfs_pkg::BANK_W-1:0] other;
		b = pbfs_pkg::BANK_W'($urandom_range(0, BANK_COUNT - 1));
		other = pbfs_pkg::BANK_W'(b + 1 + $urandom_range(0, BANK_COUNT - 2));
		send_cmd(pbfs_pkg::OP_PUT, b, rand_tag(), 1'b0);
		repeat (SCHED_DEPTH - 1)
			send_cmd(pbfs_pkg::OP_RESCHEDULE, b, rand_tag(), rand_bit());
		send_cmd(pbfs_pkg::OP_RESCHEDULE, b, rand_tag(), rand_bit());
		// The tag is stored but the bank cannot join the full schedule.
		send_cmd(pbfs_pkg::OP_PUT, other, rand_tag(), 1'b0);
		repeat (SCHED_DEPTH + 1)
			send_cmd(pbfs_pkg::OP_NEXT, rand_bank(), rand_tag(), rand_bit());
		send_cmd(pbfs_pkg::OP_COMPLETE, b, rand_tag(), rand_bit());
		send_cmd(pbfs_pkg::OP_COMPLETE, other, rand_tag(), rand_bit());
		send_cmd(pbfs_pkg::OP_RESCHEDULE, other, rand_tag(), rand_bit());
	endtask

	task automatic test_bank_overflow();
		logic [pbfs_pkg::BANK_W-1:0] b;
		b = pbfs_pkg::BANK_W'($urandom_range(0, BANK_COUNT - 1));
		send_cmd(pbfs_pkg::OP_PUT, b, rand_tag(), 1'b0);
		repeat (QUEUE_DEPTH) send_cmd(pbfs_pkg::OP_PUT, b, rand_tag(), rand_bit());
		send_cmd(pbfs_pkg::OP_NEXT, rand_bank(), rand_tag(), rand_bit());
		repeat (QUEUE_DEPTH + 1)
			send_cmd(pbfs_pkg::OP_COMPLETE, b, rand_tag(), rand_bit());
	endtask

	// Fills every bank to the brim, then drains them in random order.
	task automatic test_fill_all();
		logic [pbfs_pkg::BANK_W-1:0] b;
		while (held_total != BANK_COUNT * QUEUE_DEPTH) begin
			b = pbfs_pkg::BANK_W'($urandom_range(0, BANK_COUNT - 1));
			if (bq_cnt[b] != QUEUE_DEPTH)
				send_cmd(pbfs_pkg::OP_PUT, b, rand_tag(), $urandom_range(0, 3) == 0);
		end
		send_cmd(pbfs_pkg::OP_PUT, rand_bank(), rand_tag(), rand_bit());
		while (held_total != 0) begin
			b = pbfs_pkg::BANK_W'($urandom_range(0, BANK_COUNT - 1));
			if ($urandom_range(0, 7) == 0)
				send_cmd(pbfs_pkg::OP_NEXT, b, rand_tag(), rand_bit());
			else if (bq_cnt[b] != 0)
				send_cmd(pbfs_pkg::OP_COMPLETE, b, rand_tag(), rand_bit());
		end
		while (sched_cnt != 0)
			send_cmd(pbfs_pkg::OP_NEXT, rand_bank(), rand_tag(), rand_bit());
	endtask

	// Put, issue, complete and re-queue, as a memory controller would.
	task automatic test_issue_flow(int count);
		int r;
		logic [pbfs_pkg::BANK_W-1:0] hit;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 9);
			if (r < 4) begin
				send_cmd(pbfs_pkg::OP_PUT, rand_bank(), rand_tag(),
					$urandom_range(0, 4) == 0);
			end else if (r < 8 && sched_cnt != 0) begin
				send_cmd(pbfs_pkg::OP_NEXT, rand_bank(), rand_tag(), rand_bit());
				if (last_prediction.iv) begin
					hit = last_prediction.ib;
					send_cmd(pbfs_pkg::OP_COMPLETE, hit, rand_tag(), rand_bit());
					if ($urandom_range(0, 3) != 0)
						send_cmd(pbfs_pkg::OP_RESCHEDULE, hit, rand_tag(), rand_bit());
				end
			end else begin
				send_cmd(pbfs_pkg::op_t'($urandom_range(pbfs_pkg::OP_COMPLETE,
					pbfs_pkg::OP_RESCHEDULE)), rand_bank(), rand_tag(), rand_bit());
			end
		end
	endtask

	task automatic test_random_mix(int count);
		repeat (count)
			send_cmd(pbfs_pkg::op_t'(pbfs_pkg::OP_W'($urandom)), rand_bank(), rand_tag(),
				rand_bit());
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		op             = pbfs_pkg::OP_PUT;
		bank           = '0;
		request_tag    = '0;
		bank_pending   = 1'b0;
		mismatch_count = 0;
		exp_wr         = 0;
		exp_rd         = 0;
		gaps_on        = 1'b1;
		reset_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_schedule_overflow();
		wait_all_results();
		test_bank_overflow();
		gaps_on = 1'b0;
		test_fill_all();
		gaps_on = 1'b1;
		wait_all_results();
		test_issue_flow(80);
		test_random_mix(100);
		gaps_on = 1'b0;
		test_issue_flow(40);

		wait_all_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && outstanding() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

[per_bank_fifo_request_scheduler_unit.f]
hdl/pbfs_pkg.sv
hdl/pbfs_ctrl.sv
hdl/pbfs_datapath.sv
hdl/per_bank_fifo_request_scheduler_unit.sv
tb/tb_top.sv
